[hdl/segment_lcd_font_and_blink_scan_top_assert.svh]
// Assertion macros used by the checker file of the segment LCD engine.
`ifndef SEGMENT_LCD_FONT_AND_BLINK_SCAN_TOP_ASSERT_SVH
`define SEGMENT_LCD_FONT_AND_BLINK_SCAN_TOP_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define SLCD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("segment LCD check failed");

// Next-cycle implication, off while reset is asserted.
`define SLCD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("segment LCD check failed");

// Next-cycle implication that also holds across reset.
`define SLCD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("segment LCD check failed");

`endif

[hdl/slcd_pkg.sv]
// Shared types, codes and segment font tables of the segment LCD engine.
`default_nettype none

package slcd_pkg;

    localparam int KIND_W    = 2;
    localparam int POS_W     = 6;
    localparam int CODE_W    = 6;
    localparam int BYTE_W    = 8;
    localparam int WORD_W    = 16;
    localparam int CNT_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int N_OPS     = 3;
    localparam int OPCNT_W   = 2;

    // Request kinds on the input channel.
    localparam logic [KIND_W-1:0] KIND_WR_DISP  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WR_BLINK = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REFRESH  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_OFF_START = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PERIOD    = 1'd1;

    localparam logic [CNT_W-1:0] BLINK_OFF_START_RST = 10'd300;
    localparam logic [CNT_W-1:0] BLINK_PERIOD_RST    = 10'd600;

    // Positions from this one up use the big font.
    localparam logic [POS_W-1:0] SPLIT_POS = 6'd21;

    typedef enum logic [1:0] {
        CMD_WR_DISP,
        CMD_WR_BLINK,
        CMD_REFRESH
    } slcd_cmd_kind_t;

    // One byte update: new = (old & keep) | set.
    typedef struct packed {
        logic [POS_W-1:0]  addr;
        logic [BYTE_W-1:0] keep;
        logic [BYTE_W-1:0] set;
    } slcd_op_t;

    typedef struct packed {
        slcd_cmd_kind_t         kind;
        logic [OPCNT_W-1:0]     n_ops;
        slcd_op_t [N_OPS-1:0]   ops;
    } slcd_cmd_t;

    function automatic logic [BYTE_W-1:0] small_pat(input logic [CODE_W-1:0] code);
        logic [BYTE_W-1:0] p;
        case (code)
            6'd0:    p = 8'hAF;
            6'd1:    p = 8'h06;
            6'd2:    p = 8'h6D;
            6'd3:    p = 8'h4F;
            6'd4:    p = 8'hC6;
            6'd5:    p = 8'hCB;
            6'd6:    p = 8'hEB;
            6'd7:    p = 8'h0E;
            6'd8:    p = 8'hEF;
            6'd9:    p = 8'hCF;
            6'd10:   p = 8'hEE;
            6'd11:   p = 8'hE3;
            6'd12:   p = 8'hA9;
            6'd13:   p = 8'h67;
            6'd14:   p = 8'hE9;
            6'd15:   p = 8'hE8;
            6'd16:   p = 8'hAB;
            6'd17:   p = 8'hE6;
            6'd18:   p = 8'hA0;
            6'd19:   p = 8'h07;
            6'd20:   p = 8'hE5;
            6'd21:   p = 8'hA1;
            6'd22:   p = 8'hA7;
            6'd23:   p = 8'h62;
            6'd24:   p = 8'h63;
            6'd25:   p = 8'hEC;
            6'd26:   p = 8'hCE;
            6'd27:   p = 8'h60;
            6'd28:   p = 8'hCB;
            6'd29:   p = 8'hE1;
            6'd30:   p = 8'hA7;
            6'd31:   p = 8'h21;
            6'd32:   p = 8'hE1;
            6'd33:   p = 8'hC4;
            6'd34:   p = 8'hC7;
            6'd35:   p = 8'h41;
            6'd36:   p = 8'h40;
            6'd37:   p = 8'h01;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

    function automatic logic [BYTE_W-1:0] big_pat(input logic [CODE_W-1:0] code);
        logic [BYTE_W-1:0] p;
        case (code)
            6'd0:    p = 8'hF5;
            6'd1:    p = 8'h60;
            6'd2:    p = 8'hB6;
            6'd3:    p = 8'hF2;
            6'd4:    p = 8'h63;
            6'd5:    p = 8'hD3;
            6'd6:    p = 8'hD7;
            6'd7:    p = 8'h70;
            6'd8:    p = 8'hF7;
            6'd9:    p = 8'hF3;
            6'd10:   p = 8'h77;
            6'd11:   p = 8'hC7;
            6'd12:   p = 8'h95;
            6'd13:   p = 8'hE6;
            6'd14:   p = 8'h97;
            6'd15:   p = 8'h17;
            6'd16:   p = 8'hF3;
            6'd17:   p = 8'h85;
            6'd18:   p = 8'h46;
            6'd19:   p = 8'hC6;
            6'd20:   p = 8'h37;
            6'd21:   p = 8'h73;
            6'd22:   p = 8'hD3;
            6'd23:   p = 8'h87;
            6'd24:   p = 8'hE5;
            6'd25:   p = 8'h67;
            6'd26:   p = 8'hE3;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[hdl/segment_lcd_font_and_blink_scan_top.sv]
// Top level of the segment LCD engine: font front end, queue, store RAMs, scan back end.
//
//  Channel  Direction  Handshake            Payload
//  -------  ---------  -------------------  --------------------------------------------
//  cfg      in         cfg_we               cfg_index, cfg_wdata (10 bit)
//  s_       in         s_valid / s_ready    s_kind, s_position, s_char_code
//  m_       out        m_valid / m_ready    m_ram_address, m_segment_word, m_blank_phase
//
// A request is taken by the combinational front end and waits in a two-entry queue.
// For a character write the back end reads and then writes each byte it touches
// (one to three), as the store RAM has a registered read and a single write port.
// A refresh does a dual read of both stores, then builds the frame.
// After reset no clearing pass runs: a valid bit per store byte makes unwritten
// bytes read as all segments off, so requests are taken straight after reset.
// The queue takes requests until full while the back end waits on a full output register.
`default_nettype none

module segment_lcd_font_and_blink_scan_top #(
    parameter int RAM_BYTES = 42
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [slcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [slcd_pkg::CNT_W-1:0]        cfg_wdata,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [slcd_pkg::KIND_W-1:0]       s_kind,
    input  wire logic [slcd_pkg::POS_W-1:0]        s_position,
    input  wire logic [slcd_pkg::CODE_W-1:0]       s_char_code,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [slcd_pkg::POS_W-1:0]             m_ram_address,
    output logic [slcd_pkg::WORD_W-1:0]            m_segment_word,
    output logic                                   m_blank_phase
);

    localparam int AW = $clog2(RAM_BYTES);

    // Front end to queue.
    logic                q_push;
    logic                q_full;
    slcd_pkg::slcd_cmd_t push_cmd;

    // Queue to back end.
    logic                q_valid;
    logic                q_pop;
    slcd_pkg::slcd_cmd_t q_cmd;

    // Back end to the store RAMs.
    logic                           disp_we;
    logic                           blink_we;
    logic [AW-1:0]                  wr_addr;
    logic [slcd_pkg::BYTE_W-1:0]    wr_data;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr_a;
    logic [AW-1:0]                  rd_addr_b;
    logic [slcd_pkg::BYTE_W-1:0]    disp_rdata_a;
    logic [slcd_pkg::BYTE_W-1:0]    disp_rdata_b;
    logic [slcd_pkg::BYTE_W-1:0]    blink_rdata_a;
    logic [slcd_pkg::BYTE_W-1:0]    blink_rdata_b;

    // The front end drops writes beyond the store and unused kinds, so they
    // never occupy the queue.
    slcd_front #(
        .RAM_BYTES (RAM_BYTES)
    ) u_front (
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_position  (s_position),
        .s_char_code (s_char_code),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    slcd_queue #(
        .DEPTH (2)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // The back end runs one command at a time: byte updates for writes and
    // the two-byte frame read for refreshes.
    slcd_back #(
        .RAM_BYTES (RAM_BYTES)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .q_valid        (q_valid),
        .q_cmd          (q_cmd),
        .q_pop          (q_pop),
        .disp_we        (disp_we),
        .blink_we       (blink_we),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_en          (rd_en),
        .rd_addr_a      (rd_addr_a),
        .rd_addr_b      (rd_addr_b),
        .disp_rdata_a   (disp_rdata_a),
        .disp_rdata_b   (disp_rdata_b),
        .blink_rdata_a  (blink_rdata_a),
        .blink_rdata_b  (blink_rdata_b),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_ram_address  (m_ram_address),
        .m_segment_word (m_segment_word),
        .m_blank_phase  (m_blank_phase)
    );

    // Display store: the segment pattern shown on the glass.
    slcd_ram #(
        .WIDTH (slcd_pkg::BYTE_W),
        .DEPTH (RAM_BYTES)
    ) u_disp_ram (
        .aclk    (aclk),
        .we      (disp_we),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .re      (rd_en),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (disp_rdata_a),
        .rdata_b (disp_rdata_b)
    );

    // Blink store: segments that are blanked from the off-start count to the end of the period.
    slcd_ram #(
        .WIDTH (slcd_pkg::BYTE_W),
        .DEPTH (RAM_BYTES)
    ) u_blink_ram (
        .aclk    (aclk),
        .we      (blink_we),
        .waddr   (wr_addr),
        .wdata   (wr_data),
        .re      (rd_en),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (blink_rdata_a),
        .rdata_b (blink_rdata_b)
    );

endmodule

`default_nettype wire

[hdl/slcd_ram.sv]
// Generic single-write, dual-read RAM with registered read data.
`default_nettype none

module slcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 42,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

[hdl/slcd_front.sv]
// Front end: accepts requests, looks up the font and builds byte update lists.
`default_nettype none

module slcd_front #(
    parameter int RAM_BYTES = 42
) (
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [slcd_pkg::KIND_W-1:0]   s_kind,
    input  wire logic [slcd_pkg::POS_W-1:0]    s_position,
    input  wire logic [slcd_pkg::CODE_W-1:0]   s_char_code,
    input  wire logic                          q_full,
    output logic                               q_push,
    output slcd_pkg::slcd_cmd_t                q_cmd
);

    localparam logic [slcd_pkg::POS_W:0] RAM_BYTES_W = (slcd_pkg::POS_W + 1)'(RAM_BYTES);

    // Bytes touched by the split digits at the low positions.
    localparam logic [slcd_pkg::POS_W-1:0] ADDR_0  = 6'd0;
    localparam logic [slcd_pkg::POS_W-1:0] ADDR_2  = 6'd2;
    localparam logic [slcd_pkg::POS_W-1:0] ADDR_3  = 6'd3;
    localparam logic [slcd_pkg::POS_W-1:0] ADDR_4  = 6'd4;
    localparam logic [slcd_pkg::POS_W-1:0] ADDR_38 = 6'd38;
    localparam logic [slcd_pkg::POS_W-1:0] ADDR_39 = 6'd39;
    localparam logic [slcd_pkg::POS_W-1:0] ADDR_40 = 6'd40;

    localparam logic [slcd_pkg::POS_W-1:0] POS_0 = 6'd0;
    localparam logic [slcd_pkg::POS_W-1:0] POS_1 = 6'd1;
    localparam logic [slcd_pkg::POS_W-1:0] POS_2 = 6'd2;
    localparam logic [slcd_pkg::POS_W-1:0] POS_3 = 6'd3;

    function automatic slcd_pkg::slcd_op_t mk_op(
        input logic [slcd_pkg::POS_W-1:0]  addr,
        input logic [slcd_pkg::BYTE_W-1:0] keep,
        input logic [slcd_pkg::BYTE_W-1:0] set
    );
        slcd_pkg::slcd_op_t op;
        op.addr = addr;
        op.keep = keep;
        op.set  = set;
        return op;
    endfunction

    logic [slcd_pkg::BYTE_W-1:0] sp;
    logic [slcd_pkg::BYTE_W-1:0] bp;
    logic                        pos_ok;
    logic                        useful;

    assign sp     = slcd_pkg::small_pat(s_char_code);
    assign bp     = slcd_pkg::big_pat(s_char_code);
    assign pos_ok = {1'b0, s_position} < RAM_BYTES_W;

    always_comb begin
        q_cmd       = '0;
        q_cmd.kind  = slcd_pkg::CMD_REFRESH;
        useful      = 1'b0;
        case (s_kind)
            slcd_pkg::KIND_WR_DISP, slcd_pkg::KIND_WR_BLINK: begin
                useful     = pos_ok;
                q_cmd.kind = (s_kind == slcd_pkg::KIND_WR_DISP) ?
                             slcd_pkg::CMD_WR_DISP : slcd_pkg::CMD_WR_BLINK;
                if (s_position >= slcd_pkg::SPLIT_POS) begin
                    q_cmd.n_ops  = 2'd1;
                    q_cmd.ops[0] = mk_op(s_position, 8'h00, bp);
                end else begin
                    case (s_position)
                        POS_0: begin
                            q_cmd.n_ops  = 2'd2;
                            q_cmd.ops[0] = mk_op(ADDR_0, 8'h0F, {sp[3:0], 4'h0});
                            q_cmd.ops[1] = mk_op(ADDR_2, 8'hF0, {4'h0, sp[7:4]});
                        end
                        POS_1: begin
                            q_cmd.n_ops  = 2'd3;
                            q_cmd.ops[0] = mk_op(ADDR_39, 8'hF7, sp & 8'h08);
                            q_cmd.ops[1] = mk_op(ADDR_38, 8'h1F, sp & 8'hE0);
                            q_cmd.ops[2] = mk_op(ADDR_40, 8'hF0, {4'h0, sp[2:0], 1'b0});
                        end
                        POS_2: begin
                            q_cmd.n_ops  = 2'd2;
                            q_cmd.ops[0] = mk_op(ADDR_38, 8'hF0, sp & 8'h0F);
                            q_cmd.ops[1] = mk_op(ADDR_2, 8'h0F, sp & 8'hF0);
                        end
                        POS_3: begin
                            // Both splices into byte 4 are merged into one update.
                            q_cmd.n_ops  = 2'd2;
                            q_cmd.ops[0] = mk_op(ADDR_3, 8'hF7, sp & 8'h08);
                            q_cmd.ops[1] = mk_op(ADDR_4, 8'h11,
                                                 (sp & 8'hE0) | {4'h0, sp[2:0], 1'b0});
                        end
                        default: begin
                            q_cmd.n_ops  = 2'd1;
                            q_cmd.ops[0] = mk_op(s_position, 8'h00, sp);
                        end
                    endcase
                end
            end
            slcd_pkg::KIND_REFRESH: begin
                useful     = 1'b1;
                q_cmd.kind = slcd_pkg::CMD_REFRESH;
            end
            default: begin
                useful = 1'b0;
            end
        endcase
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && s_ready && useful;

endmodule

`default_nettype wire

[hdl/slcd_queue.sv]
// Short command queue between the front end and the back end.
`default_nettype none

module slcd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire slcd_pkg::slcd_cmd_t push_cmd,
    output logic                     full,
    input  wire logic                pop,
    output logic                     q_valid,
    output slcd_pkg::slcd_cmd_t      q_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

    slcd_pkg::slcd_cmd_t mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg;
    logic [PW-1:0] rptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == DEPTH_C);
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem_reg[rptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wptr_reg <= (wptr_reg == LAST_PTR) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop) begin
                rptr_reg <= (rptr_reg == LAST_PTR) ? '0 : rptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

[hdl/slcd_back.sv]
// Back end: byte read-modify-write sequencer, refresh scan and blink counter.
`default_nettype none

module slcd_back #(
    parameter int RAM_BYTES = 42,
    localparam int AW = $clog2(RAM_BYTES)
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration
    input  wire logic                              cfg_we,
    input  wire logic [slcd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [slcd_pkg::CNT_W-1:0]        cfg_wdata,
    // command queue
    input  wire logic                              q_valid,
    input  wire slcd_pkg::slcd_cmd_t               q_cmd,
    output logic                                   q_pop,
    // store RAMs
    output logic                                   disp_we,
    output logic                                   blink_we,
    output logic [AW-1:0]                          wr_addr,
    output logic [slcd_pkg::BYTE_W-1:0]            wr_data,
    output logic                                   rd_en,
    output logic [AW-1:0]                          rd_addr_a,
    output logic [AW-1:0]                          rd_addr_b,
    input  wire logic [slcd_pkg::BYTE_W-1:0]       disp_rdata_a,
    input  wire logic [slcd_pkg::BYTE_W-1:0]       disp_rdata_b,
    input  wire logic [slcd_pkg::BYTE_W-1:0]       blink_rdata_a,
    input  wire logic [slcd_pkg::BYTE_W-1:0]       blink_rdata_b,
    // result channel
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [slcd_pkg::POS_W-1:0]             m_ram_address,
    output logic [slcd_pkg::WORD_W-1:0]            m_segment_word,
    output logic                                   m_blank_phase
);

    localparam logic [slcd_pkg::POS_W:0] RAM_BYTES_W = (slcd_pkg::POS_W + 1)'(RAM_BYTES);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OP_RD,
        ST_OP_WR,
        ST_SCAN_RD,
        ST_SCAN_OUT
    } state_t;

    state_t                            state_reg, state_next;
    slcd_pkg::slcd_cmd_t               cmd_reg, cmd_next;
    logic [slcd_pkg::OPCNT_W-1:0]      op_idx_reg, op_idx_next;
    logic [RAM_BYTES-1:0]              disp_vld_reg, disp_vld_next;
    logic [RAM_BYTES-1:0]              blink_vld_reg, blink_vld_next;
    logic                              dv_a_reg, dv_a_next, dv_b_reg, dv_b_next;
    logic                              bv_a_reg, bv_a_next, bv_b_reg, bv_b_next;
    logic [slcd_pkg::POS_W-1:0]        scan_reg, scan_next;
    logic [slcd_pkg::CNT_W-1:0]        blink_cnt_reg, blink_cnt_next;
    logic [slcd_pkg::CNT_W-1:0]        off_start_reg, off_start_next;
    logic [slcd_pkg::CNT_W-1:0]        period_reg, period_next;
    logic                              m_valid_reg, m_valid_next;
    logic [slcd_pkg::POS_W-1:0]        m_addr_reg, m_addr_next;
    logic [slcd_pkg::WORD_W-1:0]       m_word_reg, m_word_next;
    logic                              m_blank_reg, m_blank_next;

    slcd_pkg::slcd_op_t                cur_op;
    logic [slcd_pkg::POS_W:0]          scan_plus1;
    logic [slcd_pkg::POS_W:0]          scan_plus2;
    logic [AW-1:0]                     scan_j;
    logic [slcd_pkg::CNT_W-1:0]        cnt_inc;
    logic [slcd_pkg::BYTE_W-1:0]       old_byte;
    logic [slcd_pkg::BYTE_W-1:0]       d0, d1, b0, b1;
    logic                              blank;
    logic                              out_free;
    logic                              is_disp;

    assign cur_op     = cmd_reg.ops[op_idx_reg];
    assign is_disp    = (cmd_reg.kind == slcd_pkg::CMD_WR_DISP);
    assign scan_plus1 = {1'b0, scan_reg} + 1'b1;
    assign scan_plus2 = {1'b0, scan_reg} + 2'd2;
    assign scan_j     = (scan_plus1 == RAM_BYTES_W) ? '0 : scan_plus1[AW-1:0];
    assign cnt_inc    = blink_cnt_reg + 1'b1;
    assign blank      = (blink_cnt_reg >= off_start_reg);
    assign out_free   = !m_valid_reg || m_ready;

    assign old_byte = is_disp ? (dv_a_reg ? disp_rdata_a : '0)
                              : (bv_a_reg ? blink_rdata_a : '0);

    always_comb begin
        d0 = dv_a_reg ? disp_rdata_a : '0;
        d1 = dv_b_reg ? disp_rdata_b : '0;
        b0 = bv_a_reg ? blink_rdata_a : '0;
        b1 = bv_b_reg ? blink_rdata_b : '0;
        if (blank) begin
            d0 = d0 & ~b0;
            d1 = d1 & ~b1;
        end
    end

    assign rd_en     = (state_reg == ST_OP_RD) || (state_reg == ST_SCAN_RD);
    assign rd_addr_a = (state_reg == ST_OP_RD) ? cur_op.addr[AW-1:0] : scan_reg[AW-1:0];
    assign rd_addr_b = scan_j;
    assign wr_addr   = cur_op.addr[AW-1:0];
    assign wr_data   = (old_byte & cur_op.keep) | cur_op.set;
    assign disp_we   = (state_reg == ST_OP_WR) && is_disp;
    assign blink_we  = (state_reg == ST_OP_WR) && !is_disp;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        op_idx_next    = op_idx_reg;
        disp_vld_next  = disp_vld_reg;
        blink_vld_next = blink_vld_reg;
        dv_a_next      = dv_a_reg;
        dv_b_next      = dv_b_reg;
        bv_a_next      = bv_a_reg;
        bv_b_next      = bv_b_reg;
        scan_next      = scan_reg;
        blink_cnt_next = blink_cnt_reg;
        off_start_next = off_start_reg;
        period_next    = period_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_addr_next    = m_addr_reg;
        m_word_next    = m_word_reg;
        m_blank_next   = m_blank_reg;

        if (cfg_we) begin
            case (cfg_index)
                slcd_pkg::CFG_BLINK_OFF_START: off_start_next = cfg_wdata;
                slcd_pkg::CFG_BLINK_PERIOD:    period_next    = cfg_wdata;
                default: ;
            endcase
        end

        if (rd_en) begin
            dv_a_next = disp_vld_reg[rd_addr_a];
            dv_b_next = disp_vld_reg[rd_addr_b];
            bv_a_next = blink_vld_reg[rd_addr_a];
            bv_b_next = blink_vld_reg[rd_addr_b];
        end

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    cmd_next    = q_cmd;
                    op_idx_next = '0;
                    state_next  = (q_cmd.kind == slcd_pkg::CMD_REFRESH) ?
                                  ST_SCAN_RD : ST_OP_RD;
                end
            end
            ST_OP_RD: begin
                state_next = ST_OP_WR;
            end
            ST_OP_WR: begin
                if (is_disp) begin
                    disp_vld_next[wr_addr] = 1'b1;
                end else begin
                    blink_vld_next[wr_addr] = 1'b1;
                end
                if (op_idx_reg == cmd_reg.n_ops - 1'b1) begin
                    state_next = ST_IDLE;
                end else begin
                    op_idx_next = op_idx_reg + 1'b1;
                    state_next  = ST_OP_RD;
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_OUT;
            end
            ST_SCAN_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_addr_next  = scan_reg;
                    m_word_next  = {d1[7:4], d0[7:4], d1[3:0], d0[3:0]};
                    m_blank_next = blank;
                    scan_next    = (scan_plus2 >= RAM_BYTES_W) ? 6'd1 :
                                   scan_plus2[slcd_pkg::POS_W-1:0];
                    blink_cnt_next = (cnt_inc >= period_reg) ? '0 : cnt_inc;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            op_idx_reg    <= '0;
            disp_vld_reg  <= '0;
            blink_vld_reg <= '0;
            scan_reg      <= 6'd1;
            blink_cnt_reg <= '0;
            off_start_reg <= slcd_pkg::BLINK_OFF_START_RST;
            period_reg    <= slcd_pkg::BLINK_PERIOD_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            op_idx_reg    <= op_idx_next;
            disp_vld_reg  <= disp_vld_next;
            blink_vld_reg <= blink_vld_next;
            scan_reg      <= scan_next;
            blink_cnt_reg <= blink_cnt_next;
            off_start_reg <= off_start_next;
            period_reg    <= period_next;
            m_valid_reg   <= m_valid_next;
        end
        cmd_reg     <= cmd_next;
        dv_a_reg    <= dv_a_next;
        dv_b_reg    <= dv_b_next;
        bv_a_reg    <= bv_a_next;
        bv_b_reg    <= bv_b_next;
        m_addr_reg  <= m_addr_next;
        m_word_reg  <= m_word_next;
        m_blank_reg <= m_blank_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_ram_address  = m_addr_reg;
    assign m_segment_word = m_word_reg;
    assign m_blank_phase  = m_blank_reg;

endmodule

`default_nettype wire

[hdl/slcd_checker.sv]
// Port-level checker for the segment LCD engine and its bind to the top level.
`default_nettype none

`include "segment_lcd_font_and_blink_scan_top_assert.svh"

module slcd_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [slcd_pkg::POS_W-1:0]    m_ram_address,
    input wire logic [slcd_pkg::WORD_W-1:0]   m_segment_word,
    input wire logic                          m_blank_phase
);

    // A frame waiting on the output holds until it is taken.
    `SLCD_ASSERT_NEXT(a_frame_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_segment_word) && $stable(m_ram_address) && $stable(m_blank_phase))

    // The scan only visits odd byte indexes.
    `SLCD_ASSERT_NOW(a_odd_address, aclk, aresetn, m_valid, m_ram_address[0] == 1'b1)

    // Reset drops any pending frame.
    `SLCD_ASSERT_NEXT_ALWAYS(a_reset_clears, aclk, !aresetn, !m_valid)

endmodule

bind segment_lcd_font_and_blink_scan_top slcd_checker u_slcd_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_ram_address  (m_ram_address),
    .m_segment_word (m_segment_word),
    .m_blank_phase  (m_blank_phase)
);

`default_nettype wire
